### rtl/rlmc_pkg.sv
`default_nettype none

package rlmc_pkg;

    localparam int unsigned RES_MAX = 3;

    localparam logic [7:0] FLAG_RX_DONE  = 8'h40;
    localparam logic [7:0] FLAG_CRC_ERR  = 8'h20;
    localparam logic [7:0] FLAG_TX_DONE  = 8'h08;
    localparam logic [7:0] FLAG_CAD_DONE = 8'h04;
    localparam logic [7:0] FLAG_ACTIVITY = 8'h01;
    localparam logic [7:0] MODE_EXPECTED = 8'h81;

    localparam logic [31:0] TX_TIMEOUT_RST  = 32'd30000;
    localparam logic [31:0] RX_TIMEOUT_RST  = 32'd60000;
    localparam logic [31:0] CAD_TIMEOUT_RST = 32'd100;
    localparam logic [7:0]  RSSI_OFFSET_RST = 8'd157;

    typedef enum logic [1:0] {
        CFG_TX_TIMEOUT  = 2'd0,
        CFG_RX_TIMEOUT  = 2'd1,
        CFG_CAD_TIMEOUT = 2'd2,
        CFG_RSSI_OFFSET = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_RX      = 3'd1,
        ST_CAD     = 3'd2,
        ST_TX      = 3'd3,
        ST_RESTART = 3'd4
    } link_state_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_STANDBY = 3'd1,
        ACT_RX      = 3'd2,
        ACT_CAD     = 3'd3,
        ACT_TX      = 3'd4,
        ACT_DELIVER = 3'd5,
        ACT_CRC     = 3'd6,
        ACT_RESET   = 3'd7
    } action_t;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_IRQ  = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t  mode;
        logic [31:0] now_ms;
        logic [7:0]  irq_bits;
        logic        tx_pending;
        logic [7:0]  op_mode_readback;
        logic        reset_ok;
        logic [7:0]  rx_length;
        logic [7:0]  snr_raw;
        logic [7:0]  rssi_raw;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic        unexpected;
        logic [8:0]  rssi_dbm;
        logic [7:0]  packet_len;
        link_state_t state_after;
    } result_t;

    typedef struct packed {
        logic tx_start;
        logic rx_start;
        logic cad_start;
    } time_load_t;

endpackage

`default_nettype wire

### rtl/rlmc_rssi.sv
`default_nettype none

module rlmc_rssi
    import rlmc_pkg::*;
(
    input  wire logic [7:0] snr_raw,
    input  wire logic [7:0] rssi_raw,
    input  wire logic [7:0] rssi_offset_db,
    output logic [8:0]      rssi_dbm
);

    logic signed [9:0]  snr_ext;
    logic signed [9:0]  snr_quarter;
    logic [16:0]        prod;
    logic [8:0]         boosted;
    logic signed [10:0] base;
    logic signed [10:0] corr;

    // truncation toward zero for negative SNR: add 3 before the arithmetic shift
    assign snr_ext     = $signed({{2{snr_raw[7]}}, snr_raw});
    assign snr_quarter = (snr_ext + 10'sd3) >>> 2;

    // raw * 16 / 15 == raw + raw / 15; raw / 15 == (raw * 274) >> 12 for raw < 256
    assign prod    = 17'(rssi_raw) * 17'd274;
    assign boosted = 9'(rssi_raw) + 9'(prod[16:12]);

    always_comb begin
        if (snr_quarter[9]) begin
            base = $signed({3'b000, rssi_raw}) + $signed({snr_quarter[9], snr_quarter});
        end else begin
            base = $signed({2'b00, boosted});
        end
        corr = base - $signed({3'b000, rssi_offset_db});
        if (corr < -11'sd200) begin
            rssi_dbm = 9'h138;
        end else if (corr > 11'sd127) begin
            rssi_dbm = 9'd127;
        end else begin
            rssi_dbm = corr[8:0];
        end
    end

endmodule

`default_nettype wire

### rtl/rlmc_event.sv
`default_nettype none

module rlmc_event
    import rlmc_pkg::*;
(
    input  wire item_t       item,
    input  wire link_state_t state_cur,
    input  wire logic [31:0] tx_start_time,
    input  wire logic [31:0] rx_start_time,
    input  wire logic [31:0] cad_start_time,
    input  wire logic [31:0] tx_limit_ms,
    input  wire logic [31:0] rx_limit_ms,
    input  wire logic [31:0] cad_limit_ms,
    input  wire logic [7:0]  rssi_offset_db,
    output link_state_t      state_next,
    output time_load_t       time_load,
    output result_t          res [RES_MAX],
    output logic [1:0]       res_cnt
);

    logic [31:0] tmo_start;
    logic [31:0] tmo_limit;
    logic        expired;
    logic        is_tick;
    logic        rx_done;
    logic        tx_done;
    logic        cad_done;
    logic        crc_err;
    logic        activity;
    logic        mode_ok;
    logic [8:0]  pkt_rssi;

    function automatic result_t mk_res(action_t act, logic unexp, link_state_t st);
        result_t r;
        r.action      = act;
        r.unexpected  = unexp;
        r.rssi_dbm    = '0;
        r.packet_len  = '0;
        r.state_after = st;
        return r;
    endfunction

    rlmc_rssi u_rssi (
        .snr_raw        (item.snr_raw),
        .rssi_raw       (item.rssi_raw),
        .rssi_offset_db (rssi_offset_db),
        .rssi_dbm       (pkt_rssi)
    );

    assign is_tick  = (item.mode == KIND_TICK);
    assign rx_done  = |(item.irq_bits & FLAG_RX_DONE);
    assign tx_done  = |(item.irq_bits & FLAG_TX_DONE);
    assign cad_done = |(item.irq_bits & FLAG_CAD_DONE);
    assign crc_err  = |(item.irq_bits & FLAG_CRC_ERR);
    assign activity = |(item.irq_bits & FLAG_ACTIVITY);
    assign mode_ok  = (item.op_mode_readback == MODE_EXPECTED);

    always_comb begin
        case (state_cur)
            ST_TX: begin
                tmo_start = tx_start_time;
                tmo_limit = tx_limit_ms;
            end
            ST_CAD: begin
                tmo_start = cad_start_time;
                tmo_limit = cad_limit_ms;
            end
            default: begin
                tmo_start = rx_start_time;
                tmo_limit = rx_limit_ms;
            end
        endcase
    end

    assign expired = (item.now_ms - tmo_start) > tmo_limit;

    always_comb begin
        time_load = '0;
        if (is_tick) begin
            case (state_cur)
                ST_RX:   time_load.cad_start = item.tx_pending;
                ST_CAD:  time_load.tx_start  = expired && item.tx_pending;
                ST_IDLE: begin
                    time_load.cad_start = mode_ok && item.tx_pending;
                    time_load.rx_start  = mode_ok && !item.tx_pending;
                end
                default: time_load = '0;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_cur;
        if (is_tick) begin
            case (state_cur)
                ST_RX: begin
                    if (expired) begin
                        state_next = ST_IDLE;
                    end else if (item.tx_pending) begin
                        state_next = ST_CAD;
                    end
                end
                ST_TX: begin
                    if (expired) begin
                        state_next = ST_IDLE;
                    end
                end
                ST_CAD: begin
                    if (expired) begin
                        state_next = item.tx_pending ? ST_TX : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (!mode_ok) begin
                        state_next = ST_RESTART;
                    end else if (item.tx_pending) begin
                        state_next = ST_CAD;
                    end else begin
                        state_next = ST_RX;
                    end
                end
                ST_RESTART: begin
                    if (item.reset_ok) begin
                        state_next = ST_IDLE;
                    end
                end
                default: state_next = state_cur;
            endcase
        end else begin
            if (rx_done && state_next != ST_RX) begin
                state_next = ST_IDLE;
            end
            if (tx_done) begin
                state_next = ST_IDLE;
            end
            if (cad_done && (state_next != ST_CAD || activity)) begin
                state_next = ST_IDLE;
            end
        end
    end

    // command results, in order
    always_comb begin
        link_state_t st;
        st      = state_cur;
        res_cnt = '0;
        for (int i = 0; i < RES_MAX; i++) begin
            res[i] = mk_res(ACT_NONE, 1'b0, ST_IDLE);
        end
        if (is_tick) begin
            case (state_cur)
                ST_RX: begin
                    if (item.tx_pending) begin
                        st           = ST_CAD;
                        res[res_cnt] = mk_res(ACT_CAD, 1'b0, st);
                        res_cnt      = res_cnt + 2'd1;
                    end
                    if (expired) begin
                        st           = ST_IDLE;
                        res[res_cnt] = mk_res(ACT_STANDBY, 1'b0, st);
                        res_cnt      = res_cnt + 2'd1;
                    end
                end
                ST_TX: begin
                    if (expired) begin
                        res[0]  = mk_res(ACT_STANDBY, 1'b0, ST_IDLE);
                        res_cnt = 2'd1;
                    end
                end
                ST_CAD: begin
                    if (expired) begin
                        if (item.tx_pending) begin
                            res[0]  = mk_res(ACT_STANDBY, 1'b0, ST_CAD);
                            res[1]  = mk_res(ACT_TX, 1'b0, ST_TX);
                            res_cnt = 2'd2;
                        end else begin
                            res[0]  = mk_res(ACT_STANDBY, 1'b0, ST_IDLE);
                            res_cnt = 2'd1;
                        end
                    end
                end
                ST_IDLE: begin
                    if (!mode_ok) begin
                        res[0] = mk_res(ACT_NONE, 1'b0, ST_RESTART);
                    end else if (item.tx_pending) begin
                        res[0] = mk_res(ACT_CAD, 1'b0, ST_CAD);
                    end else begin
                        res[0] = mk_res(ACT_RX, 1'b0, ST_RX);
                    end
                    res_cnt = 2'd1;
                end
                ST_RESTART: begin
                    res[0] = mk_res(ACT_RESET, 1'b0, ST_RESTART);
                    if (item.reset_ok) begin
                        res[1]  = mk_res(ACT_STANDBY, 1'b0, ST_IDLE);
                        res_cnt = 2'd2;
                    end else begin
                        res_cnt = 2'd1;
                    end
                end
                default: res_cnt = '0;
            endcase
        end else begin
            if (rx_done) begin
                if (st == ST_RX) begin
                    if (crc_err) begin
                        res[res_cnt] = mk_res(ACT_CRC, 1'b0, st);
                        res_cnt      = res_cnt + 2'd1;
                    end else if (item.rx_length != 8'd0) begin
                        res[res_cnt]            = mk_res(ACT_DELIVER, 1'b0, st);
                        res[res_cnt].rssi_dbm   = pkt_rssi;
                        res[res_cnt].packet_len = item.rx_length;
                        res_cnt                 = res_cnt + 2'd1;
                    end
                end else begin
                    st           = ST_IDLE;
                    res[res_cnt] = mk_res(ACT_STANDBY, 1'b1, st);
                    res_cnt      = res_cnt + 2'd1;
                end
            end
            if (tx_done) begin
                if (st == ST_TX) begin
                    st           = ST_IDLE;
                    res[res_cnt] = mk_res(ACT_NONE, 1'b0, st);
                end else begin
                    st           = ST_IDLE;
                    res[res_cnt] = mk_res(ACT_STANDBY, 1'b1, st);
                end
                res_cnt = res_cnt + 2'd1;
            end
            if (cad_done) begin
                if (st == ST_CAD) begin
                    if (activity) begin
                        st           = ST_IDLE;
                        res[res_cnt] = mk_res(ACT_NONE, 1'b0, st);
                        res_cnt      = res_cnt + 2'd1;
                    end
                end else begin
                    st           = ST_IDLE;
                    res[res_cnt] = mk_res(ACT_STANDBY, 1'b1, st);
                    res_cnt      = res_cnt + 2'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/rlmc_result_buf.sv
`default_nettype none

module rlmc_result_buf
    import rlmc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t load_res [RES_MAX],
    input  wire logic [1:0] load_cnt,
    output logic         free,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output logic [23:0]  m_tdata,  // action[2:0], unexpected[3], rssi_dbm[12:4],
                                   // packet_len[20:13], state_after[23:21]
    output logic         m_tlast
);

    logic       valid_reg, valid_next;
    logic [1:0] cnt_reg;
    logic [1:0] idx_reg, idx_next;
    result_t    res_reg [RES_MAX];
    result_t    cur;
    logic       take;
    logic       done;

    assign cur      = res_reg[idx_reg];
    assign m_tvalid = valid_reg;
    assign m_tlast  = (idx_reg == 2'(cnt_reg - 2'd1));
    assign m_tdata  = {cur.state_after, cur.packet_len, cur.rssi_dbm,
                       cur.unexpected, cur.action};

    assign take = valid_reg && m_tready;
    assign done = take && m_tlast;
    assign free = !valid_reg || done;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = '0;
        end else if (done) begin
            valid_next = 1'b0;
        end else if (take) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cnt_reg <= load_cnt;
            for (int i = 0; i < RES_MAX; i++) begin
                res_reg[i] <= load_res[i];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/radio_link_mode_controller.sv
// Link mode controller for a half-duplex packet radio. Each input transaction is a tick
// (s_tuser = 0) or a radio interrupt (s_tuser = 1) and yields zero to three command
// results, sent in order on the m_ side with m_tlast on the final one; a transaction
// with nothing to do yields no result. A transaction is registered, evaluated against
// the link state and timers, and its results are held in a three-entry result buffer
// that drains one result per cycle while m_tready is high. m_tvalid is registered in
// the buffer and rises once a registered transaction with results is loaded into it. A new
// transaction is accepted every cycle while the buffer keeps up; as results leave through
// the single result port, a transaction holds the next one in the input register until
// its last result is taken. The user is bound to write the timeout registers and the RSSI
// offset through cfg_* only while the block is idle; the block itself does not enforce it.
`default_nettype none

module radio_link_mode_controller
    import rlmc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,  // now_ms[31:0], irq_bits[39:32], tx_pending[40],
                                       // op_mode_readback[48:41], reset_ok[49],
                                       // rx_length[57:50], snr_raw[65:58],
                                       // rssi_raw[73:66], zero[79:74]
    input  wire logic        s_tuser,  // mode[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // action[2:0], unexpected[3], rssi_dbm[12:4],
                                       // packet_len[20:13], state_after[23:21]
    output logic             m_tlast
);

    logic [31:0] tx_tmo_reg;
    logic [31:0] rx_tmo_reg;
    logic [31:0] cad_tmo_reg;
    logic [7:0]  rssi_off_reg;

    logic        in_valid_reg;
    item_t       item_reg;
    item_t       item_in;

    link_state_t state_reg, state_next;
    logic [31:0] tx_start_reg;
    logic [31:0] rx_start_reg;
    logic [31:0] cad_start_reg;

    time_load_t  time_load;
    result_t     res [RES_MAX];
    logic [1:0]  res_cnt;
    logic        buf_free;
    logic        move;
    logic        accept;

    assign item_in.mode             = item_kind_t'(s_tuser);
    assign item_in.now_ms           = s_tdata[31:0];
    assign item_in.irq_bits         = s_tdata[39:32];
    assign item_in.tx_pending       = s_tdata[40];
    assign item_in.op_mode_readback = s_tdata[48:41];
    assign item_in.reset_ok         = s_tdata[49];
    assign item_in.rx_length        = s_tdata[57:50];
    assign item_in.snr_raw          = s_tdata[65:58];
    assign item_in.rssi_raw         = s_tdata[73:66];

    assign move     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || move;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_tmo_reg   <= TX_TIMEOUT_RST;
            rx_tmo_reg   <= RX_TIMEOUT_RST;
            cad_tmo_reg  <= CAD_TIMEOUT_RST;
            rssi_off_reg <= RSSI_OFFSET_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_TX_TIMEOUT:  tx_tmo_reg   <= cfg_wdata;
                CFG_RX_TIMEOUT:  rx_tmo_reg   <= cfg_wdata;
                CFG_CAD_TIMEOUT: cad_tmo_reg  <= cfg_wdata;
                CFG_RSSI_OFFSET: rssi_off_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (move) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_in;
        end
    end

    rlmc_event u_event (
        .item           (item_reg),
        .state_cur      (state_reg),
        .tx_start_time  (tx_start_reg),
        .rx_start_time  (rx_start_reg),
        .cad_start_time (cad_start_reg),
        .tx_limit_ms    (tx_tmo_reg),
        .rx_limit_ms    (rx_tmo_reg),
        .cad_limit_ms   (cad_tmo_reg),
        .rssi_offset_db (rssi_off_reg),
        .state_next     (state_next),
        .time_load      (time_load),
        .res            (res),
        .res_cnt        (res_cnt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RESTART;
            tx_start_reg  <= '0;
            rx_start_reg  <= '0;
            cad_start_reg <= '0;
        end else if (move) begin
            state_reg <= state_next;
            if (time_load.tx_start) begin
                tx_start_reg <= item_reg.now_ms;
            end
            if (time_load.rx_start) begin
                rx_start_reg <= item_reg.now_ms;
            end
            if (time_load.cad_start) begin
                cad_start_reg <= item_reg.now_ms;
            end
        end
    end

    rlmc_result_buf u_result_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (move && (res_cnt != 2'd0)),
        .load_res (res),
        .load_cnt (res_cnt),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_len_only_on_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != ACT_DELIVER) |-> (m_tdata[20:4] == '0))
        else $error("packet fields set on a non-deliver result");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result buffer is stalled");

    a_unexpected_is_standby: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> (m_tdata[2:0] == ACT_STANDBY) && (m_tdata[23:21] == ST_IDLE))
        else $error("unexpected flag on a result other than standby to idle");

endmodule

`default_nettype wire
